[hdl/lnfe_pkg.sv]
package lnfe_pkg;

    localparam int DIGIT_COUNT_DEF = 6;
    localparam int VALUE_W         = 20;
    localparam int FRAME_W         = 17;
    localparam int BITS_W          = 5;
    localparam int CMD_W           = 8;
    localparam int LIMIT_W         = 27;
    localparam int PROD_W          = 2 * VALUE_W;
    localparam int RECIP_SHIFT     = 23;

    localparam logic [VALUE_W-1:0] RECIP_TEN   = 20'hCCCCD;
    localparam logic [2:0]         DATA_PREFIX = 3'b101;
    localparam logic [3:0]         CMD_PREFIX  = 4'b1000;
    localparam logic [BITS_W-1:0]  DATA_BITS   = 5'd17;
    localparam logic [BITS_W-1:0]  CMD_BITS    = 5'd12;

    typedef enum logic {
        KIND_DISPLAY = 1'b0,
        KIND_COMMAND = 1'b1
    } lnfe_kind_t;

    typedef struct packed {
        lnfe_kind_t       kind;
        logic [CMD_W-1:0] cmd;
    } lnfe_head_t;

    function automatic logic [LIMIT_W-1:0] max_value(input int digits);
        logic [LIMIT_W-1:0] p;
        p = LIMIT_W'(1);
        for (int i = 0; i < digits; i++)
        begin
            p = LIMIT_W'(p * LIMIT_W'(10));
        end
        return p - LIMIT_W'(1);
    endfunction

    function automatic logic [6:0] seg_of_digit(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h7D;
            4'd1:    s = 7'h60;
            4'd2:    s = 7'h3E;
            4'd3:    s = 7'h7A;
            4'd4:    s = 7'h63;
            4'd5:    s = 7'h5B;
            4'd6:    s = 7'h5F;
            4'd7:    s = 7'h70;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h7B;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

[hdl/lnfe_item_if.sv]
interface lnfe_item_if;
    import lnfe_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [VALUE_W-1:0]  value;
    logic [1:0]          point_position;
    logic                battery_one;
    logic                battery_two;
    logic                battery_three;
    logic [CMD_W-1:0]    command_code;

    modport source (
        output valid, kind, value, point_position, battery_one, battery_two,
               battery_three, command_code,
        input  ready
    );

    modport sink (
        input  valid, kind, value, point_position, battery_one, battery_two,
               battery_three, command_code,
        output ready
    );
endinterface

[hdl/lnfe_result_if.sv]
interface lnfe_result_if;
    import lnfe_pkg::*;

    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  frame;
    logic [BITS_W-1:0]   frame_bits;
    logic                last;

    modport source (
        output valid, frame, frame_bits, last,
        input  ready
    );

    modport sink (
        input  valid, frame, frame_bits, last,
        output ready
    );
endinterface

[hdl/lnfe_frame_ser.sv]
module lnfe_frame_ser
    import lnfe_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load_valid,
    output logic                         load_ready,
    input  lnfe_head_t                   head,
    input  logic [DIGIT_COUNT-1:0][3:0]  digits,
    input  logic [DIGIT_COUNT-1:0]       marks,
    lnfe_result_if.source                result
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

    logic                        busy_reg, busy_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    lnfe_head_t                  head_reg;
    logic [DIGIT_COUNT-1:0][3:0] dig_reg;
    logic [DIGIT_COUNT-1:0]      mark_reg;

    logic                        is_last;
    logic                        take;
    logic                        load;
    logic [5:0]                  addr;
    logic [7:0]                  seg;

    always_comb
    begin
        is_last    = (head_reg.kind == KIND_COMMAND) || (idx_reg == IDX_LAST);
        take       = busy_reg && result.ready;
        load_ready = !busy_reg || (take && is_last);
        load       = load_valid && load_ready;

        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end

        addr = 6'({idx_reg, 1'b0});
        seg  = {mark_reg[idx_reg], seg_of_digit(dig_reg[idx_reg])};

        result.valid = busy_reg;
        result.last  = is_last;
        if (head_reg.kind == KIND_COMMAND)
        begin
            result.frame      = FRAME_W'({CMD_PREFIX, head_reg.cmd});
            result.frame_bits = CMD_BITS;
        end
        else
        begin
            result.frame      = {DATA_PREFIX, addr, seg};
            result.frame_bits = DATA_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            head_reg <= head;
            dig_reg  <= digits;
            mark_reg <= marks;
        end
    end

endmodule

[hdl/lcd_number_frame_encoder_unit.sv]
// Stages: saturate and flag decode, one stage per decimal digit, then the frame serializer.
// Throughput: one frame per cycle on the result port while result.ready is high; a display
// item yields DIGIT_COUNT frames (6 by default), a command item a single frame.
// Reset: rst_n clears all valid bits and the serializer; payload registers keep their contents.
module lcd_number_frame_encoder_unit
    import lnfe_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lnfe_item_if.sink     item,
    lnfe_result_if.source result
);

    localparam int N = DIGIT_COUNT;
    localparam logic [LIMIT_W-1:0] VAL_LIMIT = max_value(DIGIT_COUNT);

    logic [N+1:0]            rdy;
    logic                    vld_reg  [0:N];
    lnfe_head_t              head_reg [0:N];
    logic [N-1:0]            mark_reg [0:N];
    logic [VALUE_W-1:0]      val_reg  [0:N-1];
    logic [N-1:0][3:0]       dig_reg  [1:N];

    logic [VALUE_W-1:0]      val_next;
    logic [N-1:0]            mark_next;
    lnfe_head_t              head_next;

    always_comb
    begin
        if ({(LIMIT_W - VALUE_W)'(0), item.value} > VAL_LIMIT)
        begin
            val_next = VAL_LIMIT[VALUE_W-1:0];
        end
        else
        begin
            val_next = item.value;
        end
        for (int i = 0; i < N; i++)
        begin
            mark_next[i] = ((item.point_position != 2'd0) && (int'(item.point_position) == i + 1))
                         || ((i == 3) && item.battery_one)
                         || ((i == 4) && item.battery_two)
                         || ((i == 5) && item.battery_three);
        end
        head_next.kind = lnfe_kind_t'(item.kind);
        head_next.cmd  = item.command_code;
    end

    assign item.ready = rdy[0];

    // stage 0: saturate and decode flags
    assign rdy[0] = !vld_reg[0] || rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (rdy[0])
        begin
            vld_reg[0] <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && item.valid)
        begin
            head_reg[0] <= head_next;
            mark_reg[0] <= mark_next;
            val_reg[0]  <= val_next;
        end
    end

    // stages 1..N: peel one decimal digit each
    for (genvar s = 1; s <= N; s++)
    begin : g_digit
        logic [PROD_W-1:0]  prod;
        logic [16:0]        quot;
        logic [VALUE_W-1:0] tenq;
        logic [VALUE_W-1:0] rem;
        logic [N-1:0][3:0]  dig_next;

        always_comb
        begin
            prod = PROD_W'(val_reg[s-1]) * PROD_W'(RECIP_TEN);
            quot = prod[RECIP_SHIFT +: 17];
            tenq = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
            rem  = val_reg[s-1] - tenq;
            if (s == 1)
            begin
                dig_next = '0;
            end
            else
            begin
                dig_next = dig_reg[(s > 1) ? s - 1 : 1];
            end
            dig_next[s-1] = rem[3:0];
        end

        assign rdy[s] = !vld_reg[s] || rdy[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && vld_reg[s-1])
            begin
                head_reg[s] <= head_reg[s-1];
                mark_reg[s] <= mark_reg[s-1];
                dig_reg[s]  <= dig_next;
            end
        end

        if (s < N)
        begin : g_val
            always_ff @(posedge clk)
            begin
                if (rdy[s] && vld_reg[s-1])
                begin
                    val_reg[s] <= {3'b000, quot};
                end
            end
        end
    end

    lnfe_frame_ser #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (vld_reg[N]),
        .load_ready (rdy[N+1]),
        .head       (head_reg[N]),
        .digits     (dig_reg[N]),
        .marks      (mark_reg[N]),
        .result     (result)
    );

endmodule
